// ----- rtl/core/thp_pkg.sv -----
// Shared types and constants of the tunnel header parser.
`timescale 1ns / 1ps
`default_nettype none
package thp_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ETHER = 3'd1;
  localparam logic [2:0] ST_NOTIP = 3'd2;
  localparam logic [2:0] ST_UNSUP = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;
  localparam logic [2:0] ST_INNER = 3'd5;

  // Layer 4 kinds
  localparam logic [1:0] KIND_TCP  = 2'd0;
  localparam logic [1:0] KIND_UDP  = 2'd1;
  localparam logic [1:0] KIND_GRE  = 2'd2;
  localparam logic [1:0] KIND_ICMP = 2'd3;

  // Tunnel kinds
  localparam logic [1:0] TUN_NONE  = 2'd0;
  localparam logic [1:0] TUN_GRE   = 2'd1;
  localparam logic [1:0] TUN_VXLAN = 2'd2;
  localparam logic [1:0] TUN_GTPU  = 2'd3;

  // IP protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_GRE  = 8'd47;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  // Configuration register indexes
  localparam logic CFG_VXLAN_PORT = 1'b0;
  localparam logic CFG_GTPU_PORT  = 1'b1;

  // Header being walked at the current byte
  typedef enum logic [3:0] {
    PH_ETH, PH_IP, PH_OPT, PH_TCP, PH_UDP, PH_GRE, PH_TUN, PH_GSKIP, PH_DONE, PH_FAIL
  } phase_t;

  // One result item; the last member sits in the lowest bits
  typedef struct packed {
    logic [15:0] inner_dst_port;
    logic [15:0] inner_src_port;
    logic [31:0] inner_dst_ip;
    logic [31:0] inner_src_ip;
    logic [31:0] tunnel_id;
    logic [1:0]  tunnel_kind;
    logic [3:0]  l4_kinds;
    logic [15:0] outer_dst_port;
    logic [15:0] outer_src_port;
    logic [31:0] outer_dst_ip;
    logic [31:0] outer_src_ip;
    logic [2:0]  parse_status;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/tunnel_header_parser.sv -----
// Top level of the Ethernet / IPv4 tunnel header parser.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[7:0] data_byte, tlast last_byte
//   out_     master     tdata[232:0] one result item, zero filled to 240 bits
//   cfg_     write      addr 0 VXLAN UDP port, addr 1 GTP-U UDP port
//
// One byte is taken every cycle; each byte passes through the header walker,
// and a result is registered on the packet's last byte.
// The result appears in the cycle after that byte and waits in the output register.
// Input stalls only while a result is held and the output is not ready.
// Reset is synchronous and active low; it restores both port registers.
`timescale 1ns / 1ps
`default_nettype none
module tunnel_header_parser (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [7:0]   in_tdata,   // data_byte
  input  wire          in_tlast,   // last_byte
  output logic         out_tvalid,
  input  wire          out_tready,
  // parse_status, outer_src_ip, outer_dst_ip, outer_src_port, outer_dst_port,
  // l4_kinds, tunnel_kind, tunnel_id, inner_src_ip, inner_dst_ip,
  // inner_src_port, inner_dst_port, then zero fill
  output logic [239:0] out_tdata,
  input  wire          cfg_we,
  input  wire          cfg_addr,
  input  wire  [15:0]  cfg_wdata
);

  logic [15:0]      vxlan_port_r, vxlan_port_nxt, gtpu_port_r, gtpu_port_nxt;
  logic             acc, room;
  thp_pkg::result_t res, res_q;

  // Configuration registers
  always_comb begin
    vxlan_port_nxt = vxlan_port_r;
    gtpu_port_nxt  = gtpu_port_r;
    if (cfg_we) begin
      case (cfg_addr)
        thp_pkg::CFG_VXLAN_PORT: vxlan_port_nxt = cfg_wdata;
        thp_pkg::CFG_GTPU_PORT:  gtpu_port_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vxlan_port_r <= 16'd4789;
      gtpu_port_r  <= 16'd2152;
    end else begin
      vxlan_port_r <= vxlan_port_nxt;
      gtpu_port_r  <= gtpu_port_nxt;
    end
  end

  // Input handshake
  assign in_tready = room;
  assign acc       = in_tvalid && room;

  thp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .vxlan_port (vxlan_port_r),
    .gtpu_port  (gtpu_port_r),
    .res        (res)
  );

  thp_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (acc && in_tlast),
    .res_in  (res),
    .room    (room),
    .valid   (out_tvalid),
    .ready   (out_tready),
    .res_out (res_q)
  );

  assign out_tdata = {7'd0, res_q};

  // A last byte always yields a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> out_tvalid)
    else $error("last byte produced no result item");

  // A failed parse carries no tunnel and no addresses
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_q.parse_status != thp_pkg::ST_OK) |->
      (res_q.tunnel_kind == thp_pkg::TUN_NONE && res_q.outer_src_ip == '0))
    else $error("failed parse result has non-zero fields");

  // Without a tunnel the inner fields stay clear
  a_no_tunnel_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_q.tunnel_kind == thp_pkg::TUN_NONE) |->
      (res_q.inner_src_ip == '0 && res_q.tunnel_id == '0 && res_q.l4_kinds[1:0] == 2'd0))
    else $error("inner fields set without tunnel");

endmodule
`default_nettype wire

// ----- rtl/core/thp_parser.sv -----
// Byte-at-a-time header walker that builds the result of each packet.
`timescale 1ns / 1ps
`default_nettype none
module thp_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 acc,
  input  wire  [7:0]          data_byte,
  input  wire                 last_byte,
  input  wire  [15:0]         vxlan_port,
  input  wire  [15:0]         gtpu_port,
  output thp_pkg::result_t    res
);

  thp_pkg::phase_t phase_r, phase_nxt, phase_upd;
  logic [5:0]  idx_r, idx_nxt, idx_upd;
  logic [5:0]  lim_r, lim_nxt, lim_upd;
  logic        inner_r, inner_nxt, inner_upd;
  logic [1:0]  tun_r, tun_nxt, tun_upd;
  logic [7:0]  scr_r, scr_nxt, scr_upd;
  logic [7:0]  proto_r, proto_nxt, proto_upd;
  logic [2:0]  err_r, err_nxt, err_upd;
  logic [31:0] o_src_r, o_src_nxt, o_src_upd, o_dst_r, o_dst_nxt, o_dst_upd;
  logic [31:0] i_src_r, i_src_nxt, i_src_upd, i_dst_r, i_dst_nxt, i_dst_upd;
  logic [15:0] o_sp_r, o_sp_nxt, o_sp_upd, o_dp_r, o_dp_nxt, o_dp_upd;
  logic [15:0] i_sp_r, i_sp_nxt, i_sp_upd, i_dp_r, i_dp_nxt, i_dp_upd;
  logic [1:0]  o_kind_r, o_kind_nxt, o_kind_upd, i_kind_r, i_kind_nxt, i_kind_upd;
  logic [31:0] tid_r, tid_nxt, tid_upd;

  logic [31:0] cur_src, cur_dst, dst_full;
  logic [15:0] cur_sp, cur_dp;
  logic        src_w, dst_w, sp_w, dp_w, kind_w, do_disp, do_fail;
  logic [1:0]  kind_val;
  logic [2:0]  fail_code;
  logic [5:0]  tcp_len, gre_lim;
  logic [2:0]  st;
  logic        ok, tk_ok;

  // Fields of the layer now being parsed
  assign cur_src  = inner_r ? i_src_r : o_src_r;
  assign cur_dst  = inner_r ? i_dst_r : o_dst_r;
  assign cur_sp   = inner_r ? i_sp_r  : o_sp_r;
  assign cur_dp   = inner_r ? i_dp_r  : o_dp_r;
  assign dst_full = {cur_dst[23:0], data_byte};
  assign tcp_len  = {data_byte[7:4], 2'b00};
  assign gre_lim  = 6'd3 + (scr_r[5] ? 6'd4 : 6'd0) + (scr_r[4] ? 6'd4 : 6'd0);

  // Effect of one byte on the walk
  always_comb begin
    phase_upd = phase_r;  idx_upd = idx_r + 6'd1;  lim_upd = lim_r;
    inner_upd = inner_r;  tun_upd = tun_r;  scr_upd = scr_r;  proto_upd = proto_r;
    err_upd = err_r;  tid_upd = tid_r;
    src_w = 1'b0;  dst_w = 1'b0;  sp_w = 1'b0;  dp_w = 1'b0;  kind_w = 1'b0;
    kind_val = thp_pkg::KIND_TCP;  do_disp = 1'b0;  do_fail = 1'b0;
    fail_code = thp_pkg::ST_UNSUP;
    case (phase_r)
      thp_pkg::PH_ETH: begin
        if (idx_r == 6'd12) scr_upd = data_byte;
        if (idx_r == 6'd13) begin
          if ({scr_r, data_byte} != thp_pkg::ETYPE_IPV4) begin
            do_fail = 1'b1;  fail_code = thp_pkg::ST_ETHER;
          end else begin
            phase_upd = thp_pkg::PH_IP;  idx_upd = '0;
          end
        end
      end
      thp_pkg::PH_IP: begin
        if (idx_r == 6'd0) scr_upd = data_byte;
        if (idx_r == 6'd9) proto_upd = data_byte;
        if (idx_r >= 6'd12 && idx_r <= 6'd15) src_w = 1'b1;
        if (idx_r >= 6'd16 && idx_r <= 6'd19) dst_w = 1'b1;
        if (idx_r == 6'd19) begin
          if (scr_r[7:4] != 4'd4 || scr_r[3:0] < 4'd5 || cur_src == '0 || dst_full == '0)
          begin
            do_fail = 1'b1;  fail_code = thp_pkg::ST_NOTIP;
          end else if (scr_r[3:0] == 4'd5) begin
            do_disp = 1'b1;
          end else begin
            phase_upd = thp_pkg::PH_OPT;  idx_upd = '0;
            lim_upd = {scr_r[3:0], 2'b00} - 6'd21;
          end
        end
      end
      thp_pkg::PH_OPT: begin
        if (idx_r == lim_r) do_disp = 1'b1;
      end
      thp_pkg::PH_TCP: begin
        if (idx_r <= 6'd1) sp_w = 1'b1;
        if (idx_r == 6'd2 || idx_r == 6'd3) dp_w = 1'b1;
        if (idx_r == 6'd12) begin
          if (tcp_len <= 6'd13) phase_upd = thp_pkg::PH_DONE;
          else lim_upd = tcp_len - 6'd1;
        end else if (idx_r > 6'd12 && idx_r == lim_r) begin
          phase_upd = thp_pkg::PH_DONE;
        end
      end
      thp_pkg::PH_UDP: begin
        if (idx_r <= 6'd1) sp_w = 1'b1;
        if (idx_r == 6'd2 || idx_r == 6'd3) dp_w = 1'b1;
        if (idx_r == 6'd7) begin
          idx_upd = '0;
          if (!inner_r && cur_dp == vxlan_port) begin
            tun_upd = thp_pkg::TUN_VXLAN;  phase_upd = thp_pkg::PH_TUN;
          end else if (!inner_r && cur_dp == gtpu_port) begin
            tun_upd = thp_pkg::TUN_GTPU;  phase_upd = thp_pkg::PH_TUN;
          end else begin
            phase_upd = thp_pkg::PH_DONE;
          end
        end
      end
      thp_pkg::PH_GRE: begin
        if (idx_r == 6'd0) scr_upd = data_byte;
        if (idx_r >= 6'd4 && idx_r <= 6'd7 && scr_r[5]) tid_upd = {tid_r[23:0], data_byte};
        if (idx_r == 6'd3 && scr_r[7]) begin
          phase_upd = thp_pkg::PH_DONE;
        end else if (idx_r >= 6'd3 && idx_r == gre_lim) begin
          tun_upd = thp_pkg::TUN_GRE;  inner_upd = 1'b1;
          phase_upd = thp_pkg::PH_IP;  idx_upd = '0;
        end
      end
      thp_pkg::PH_TUN: begin
        if (idx_r == 6'd0) scr_upd = data_byte;
        if (idx_r >= 6'd4 && idx_r <= 6'd7) tid_upd = {tid_r[23:0], data_byte};
        if (idx_r == 6'd7) begin
          idx_upd = '0;
          if (tun_r == thp_pkg::TUN_VXLAN) begin
            if (scr_r[3]) begin
              inner_upd = 1'b1;  phase_upd = thp_pkg::PH_ETH;
            end else begin
              tun_upd = thp_pkg::TUN_NONE;  phase_upd = thp_pkg::PH_DONE;
            end
          end else begin
            inner_upd = 1'b1;
            phase_upd = (scr_r[2:0] != 3'd0) ? thp_pkg::PH_GSKIP : thp_pkg::PH_IP;
          end
        end
      end
      thp_pkg::PH_GSKIP: begin
        if (idx_r == 6'd3) begin
          phase_upd = thp_pkg::PH_IP;  idx_upd = '0;
        end
      end
      default: ;
    endcase

    // Choose the layer 4 header once the IPv4 header is complete
    if (do_disp) begin
      idx_upd = '0;
      case (proto_r)
        thp_pkg::PROTO_TCP: begin
          kind_w = 1'b1;  kind_val = thp_pkg::KIND_TCP;  phase_upd = thp_pkg::PH_TCP;
        end
        thp_pkg::PROTO_UDP: begin
          kind_w = 1'b1;  kind_val = thp_pkg::KIND_UDP;  phase_upd = thp_pkg::PH_UDP;
        end
        thp_pkg::PROTO_GRE: begin
          kind_w = 1'b1;  kind_val = thp_pkg::KIND_GRE;
          phase_upd = inner_r ? thp_pkg::PH_DONE : thp_pkg::PH_GRE;
        end
        thp_pkg::PROTO_ICMP: begin
          kind_w = 1'b1;  kind_val = thp_pkg::KIND_ICMP;  phase_upd = thp_pkg::PH_DONE;
        end
        default: begin
          do_fail = 1'b1;  fail_code = thp_pkg::ST_UNSUP;
        end
      endcase
    end

    // A failed inner layer reports ST_INNER instead of its own code
    if (do_fail) begin
      phase_upd = thp_pkg::PH_FAIL;
      err_upd   = inner_r ? thp_pkg::ST_INNER : fail_code;
    end
  end

  // Captured field updates, steered to the outer or inner set
  always_comb begin
    o_src_upd = o_src_r;  o_dst_upd = o_dst_r;  i_src_upd = i_src_r;  i_dst_upd = i_dst_r;
    o_sp_upd = o_sp_r;  o_dp_upd = o_dp_r;  i_sp_upd = i_sp_r;  i_dp_upd = i_dp_r;
    o_kind_upd = o_kind_r;  i_kind_upd = i_kind_r;
    if (inner_r) begin
      if (src_w)  i_src_upd  = {cur_src[23:0], data_byte};
      if (dst_w)  i_dst_upd  = dst_full;
      if (sp_w)   i_sp_upd   = {cur_sp[7:0], data_byte};
      if (dp_w)   i_dp_upd   = {cur_dp[7:0], data_byte};
      if (kind_w) i_kind_upd = kind_val;
    end else begin
      if (src_w)  o_src_upd  = {cur_src[23:0], data_byte};
      if (dst_w)  o_dst_upd  = dst_full;
      if (sp_w)   o_sp_upd   = {cur_sp[7:0], data_byte};
      if (dp_w)   o_dp_upd   = {cur_dp[7:0], data_byte};
      if (kind_w) o_kind_upd = kind_val;
    end
  end

  // Result of a packet that ends on this byte
  always_comb begin
    case (phase_upd)
      thp_pkg::PH_DONE: st = thp_pkg::ST_OK;
      thp_pkg::PH_FAIL: st = err_upd;
      default:          st = thp_pkg::ST_SHORT;
    endcase
    ok    = (st == thp_pkg::ST_OK);
    tk_ok = ok && (tun_upd != thp_pkg::TUN_NONE);
    res.parse_status   = st;
    res.outer_src_ip   = ok ? o_src_upd : '0;
    res.outer_dst_ip   = ok ? o_dst_upd : '0;
    res.outer_src_port = ok ? o_sp_upd : '0;
    res.outer_dst_port = ok ? o_dp_upd : '0;
    res.l4_kinds       = ok ? {o_kind_upd, (tk_ok ? i_kind_upd : 2'd0)} : 4'd0;
    res.tunnel_kind    = tk_ok ? tun_upd : thp_pkg::TUN_NONE;
    res.tunnel_id      = tk_ok ? tid_upd : '0;
    res.inner_src_ip   = tk_ok ? i_src_upd : '0;
    res.inner_dst_ip   = tk_ok ? i_dst_upd : '0;
    res.inner_src_port = tk_ok ? i_sp_upd : '0;
    res.inner_dst_port = tk_ok ? i_dp_upd : '0;
  end

  // Next state: hold when idle, restart after the last byte
  always_comb begin
    phase_nxt = phase_r;  idx_nxt = idx_r;  lim_nxt = lim_r;  inner_nxt = inner_r;
    tun_nxt = tun_r;  scr_nxt = scr_r;  proto_nxt = proto_r;  err_nxt = err_r;
    tid_nxt = tid_r;  o_src_nxt = o_src_r;  o_dst_nxt = o_dst_r;  i_src_nxt = i_src_r;
    i_dst_nxt = i_dst_r;  o_sp_nxt = o_sp_r;  o_dp_nxt = o_dp_r;  i_sp_nxt = i_sp_r;
    i_dp_nxt = i_dp_r;  o_kind_nxt = o_kind_r;  i_kind_nxt = i_kind_r;
    if (acc && last_byte) begin
      phase_nxt = thp_pkg::PH_ETH;  idx_nxt = '0;  lim_nxt = '0;  inner_nxt = 1'b0;
      tun_nxt = thp_pkg::TUN_NONE;  scr_nxt = '0;  proto_nxt = '0;  err_nxt = '0;
      tid_nxt = '0;  o_src_nxt = '0;  o_dst_nxt = '0;  i_src_nxt = '0;  i_dst_nxt = '0;
      o_sp_nxt = '0;  o_dp_nxt = '0;  i_sp_nxt = '0;  i_dp_nxt = '0;
      o_kind_nxt = '0;  i_kind_nxt = '0;
    end else if (acc) begin
      phase_nxt = phase_upd;  idx_nxt = idx_upd;  lim_nxt = lim_upd;  inner_nxt = inner_upd;
      tun_nxt = tun_upd;  scr_nxt = scr_upd;  proto_nxt = proto_upd;  err_nxt = err_upd;
      tid_nxt = tid_upd;  o_src_nxt = o_src_upd;  o_dst_nxt = o_dst_upd;
      i_src_nxt = i_src_upd;  i_dst_nxt = i_dst_upd;  o_sp_nxt = o_sp_upd;
      o_dp_nxt = o_dp_upd;  i_sp_nxt = i_sp_upd;  i_dp_nxt = i_dp_upd;
      o_kind_nxt = o_kind_upd;  i_kind_nxt = i_kind_upd;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= thp_pkg::PH_ETH;  idx_r <= '0;  lim_r <= '0;  inner_r <= 1'b0;
      tun_r <= thp_pkg::TUN_NONE;  scr_r <= '0;  proto_r <= '0;  err_r <= '0;
      tid_r <= '0;  o_src_r <= '0;  o_dst_r <= '0;  i_src_r <= '0;  i_dst_r <= '0;
      o_sp_r <= '0;  o_dp_r <= '0;  i_sp_r <= '0;  i_dp_r <= '0;
      o_kind_r <= '0;  i_kind_r <= '0;
    end else begin
      phase_r <= phase_nxt;  idx_r <= idx_nxt;  lim_r <= lim_nxt;  inner_r <= inner_nxt;
      tun_r <= tun_nxt;  scr_r <= scr_nxt;  proto_r <= proto_nxt;  err_r <= err_nxt;
      tid_r <= tid_nxt;  o_src_r <= o_src_nxt;  o_dst_r <= o_dst_nxt;
      i_src_r <= i_src_nxt;  i_dst_r <= i_dst_nxt;  o_sp_r <= o_sp_nxt;
      o_dp_r <= o_dp_nxt;  i_sp_r <= i_sp_nxt;  i_dp_r <= i_dp_nxt;
      o_kind_r <= o_kind_nxt;  i_kind_r <= i_kind_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/thp_out_reg.sv -----
// Output register that holds a result item until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module thp_out_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  thp_pkg::result_t    res_in,
  output logic                room,
  output logic                valid,
  input  wire                 ready,
  output thp_pkg::result_t    res_out
);

  logic             valid_r, valid_nxt;
  thp_pkg::result_t data_r, data_nxt;

  // Room for a new item when empty or being emptied this cycle
  assign room = !valid_r || ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res_in;
    end else if (ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid   = valid_r;
  assign res_out = data_r;

endmodule
`default_nettype wire
